// ----- rtl/stereo_mic_block_health_monitor_assert.svh -----
// Assertion macros for the checker file of the stereo health monitor.
// Expects signals named clock and reset in the including scope.
`ifndef STEREO_MIC_BLOCK_HEALTH_MONITOR_ASSERT_SVH
`define STEREO_MIC_BLOCK_HEALTH_MONITOR_ASSERT_SVH

// same-cycle implication
`define SMBHM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMBHM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/smbhm_pkg.sv -----
// Package of the stereo microphone block health monitor: field widths,
// reset constants, status codes and controller/datapath command types.
package smbhm_pkg;

   localparam int RAW_W        = 32;
   localparam int SAMPLE_W     = 24;
   localparam int SAMPLE_SHIFT = 8;
   localparam int THRESH_W     = 24;
   localparam int STATUS_W     = 3;
   localparam int COUNT_OUT_W  = 9;
   localparam int REPEAT_OUT_W = 8;

   localparam logic [THRESH_W-1:0]        THRESH_RESET = 24'd64;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX_C = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN_C = 24'sh800000;

   typedef enum logic [STATUS_W-1:0] {
      ST_NO_DATA  = 3'd0,
      ST_ALL_ZERO = 3'd1,
      ST_STUCK    = 3'd2,
      ST_LOW_VAR  = 3'd3,
      ST_ACTIVE   = 3'd4
   } status_type;

   typedef struct packed {
      logic capture;
      logic accum;
      logic div_start;
      logic load_out;
      logic clear;
      logic slot;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } stat_type;

endpackage

// ----- rtl/smbhm_div.sv -----
// Restoring divider, one quotient bit per cycle, for the mean absolute value.
// Standalone; no package dependency.
module smbhm_div #(
   parameter int DIVIDEND_W = 33,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   assign trial = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         step_in = STEP_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = (step_ff != '0);
   assign quotient = quo_ff;

endmodule

// ----- rtl/smbhm_dp.sv -----
// Datapath: per-slot statistics, threshold register, divider and result register.
// Depends on smbhm_pkg and smbhm_div.
module smbhm_dp #(
   parameter int BLOCK_FRAMES = 256
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  smbhm_pkg::cmd_type                            cmd,
   output smbhm_pkg::stat_type                           stat,
   input  logic signed [smbhm_pkg::RAW_W-1:0]            req_left_raw,
   input  logic signed [smbhm_pkg::RAW_W-1:0]            req_right_raw,
   input  logic                                          req_has_frame,
   input  logic                                          csr_write,
   input  logic [smbhm_pkg::THRESH_W-1:0]                csr_data,
   output logic                                          rsp_slot,
   output logic [smbhm_pkg::STATUS_W-1:0]                rsp_status,
   output logic [smbhm_pkg::COUNT_OUT_W-1:0]             rsp_frame_count,
   output logic signed [smbhm_pkg::SAMPLE_W-1:0]         rsp_min_sample,
   output logic signed [smbhm_pkg::SAMPLE_W-1:0]         rsp_max_sample,
   output logic [smbhm_pkg::SAMPLE_W-1:0]                rsp_sample_range,
   output logic [smbhm_pkg::SAMPLE_W-1:0]                rsp_mean_abs,
   output logic [smbhm_pkg::COUNT_OUT_W-1:0]             rsp_zero_samples,
   output logic [smbhm_pkg::REPEAT_OUT_W-1:0]            rsp_repeat_samples,
   output logic                                          rsp_last_result
);

   localparam int CNT_W = $clog2(BLOCK_FRAMES + 1);
   localparam int SUM_W = smbhm_pkg::SAMPLE_W + CNT_W;
   localparam int SW    = smbhm_pkg::SAMPLE_W;

   logic signed [smbhm_pkg::RAW_W-1:0] left_raw_ff, right_raw_ff;
   logic                               has_frame_ff;
   logic [smbhm_pkg::THRESH_W-1:0]     thresh_ff, thresh_in;
   logic [CNT_W-1:0]                   frames_ff, frames_in;

   logic signed [SW-1:0] min_ff [2];
   logic signed [SW-1:0] min_in [2];
   logic signed [SW-1:0] max_ff [2];
   logic signed [SW-1:0] max_in [2];
   logic signed [SW-1:0] prior_ff [2];
   logic signed [SW-1:0] prior_in [2];
   logic                 prior_valid_ff [2];
   logic                 prior_valid_in [2];
   logic [SUM_W-1:0]     abs_ff [2];
   logic [SUM_W-1:0]     abs_in [2];
   logic [CNT_W-1:0]     zero_ff [2];
   logic [CNT_W-1:0]     zero_in [2];
   logic [CNT_W-1:0]     rep_ff [2];
   logic [CNT_W-1:0]     rep_in [2];

   logic signed [SW-1:0] sample [2];
   logic [SW-1:0]        mag [2];
   logic                 take;

   logic                 div_busy;
   logic [SUM_W-1:0]     quotient;

   logic                 rsp_slot_ff;
   smbhm_pkg::status_type rsp_status_ff, status_c;
   logic [smbhm_pkg::COUNT_OUT_W-1:0]  rsp_frame_count_ff, rsp_zero_ff;
   logic [smbhm_pkg::REPEAT_OUT_W-1:0] rsp_repeat_ff;
   logic signed [SW-1:0] rsp_min_ff, rsp_max_ff, sel_min, sel_max;
   logic [SW-1:0]        rsp_range_ff, rsp_mean_ff, range_c;
   logic [CNT_W:0]       rep_plus;
   logic                 empty;

   // capture the item's payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_raw_ff  <= req_left_raw;
         right_raw_ff <= req_right_raw;
         has_frame_ff <= req_has_frame;
      end
   end

   assign sample[0] = left_raw_ff[smbhm_pkg::RAW_W-1:smbhm_pkg::SAMPLE_SHIFT];
   assign sample[1] = right_raw_ff[smbhm_pkg::RAW_W-1:smbhm_pkg::SAMPLE_SHIFT];
   assign take      = has_frame_ff && (frames_ff < CNT_W'(BLOCK_FRAMES));

   always_comb begin
      thresh_in = csr_write ? csr_data : thresh_ff;
      frames_in = frames_ff;
      if (cmd.clear) begin
         frames_in = '0;
      end else if (cmd.accum && take) begin
         frames_in = frames_ff + 1'b1;
      end
      for (int s = 0; s < 2; s++) begin
         mag[s]            = sample[s][SW-1] ? SW'(-sample[s]) : SW'(sample[s]);
         min_in[s]         = min_ff[s];
         max_in[s]         = max_ff[s];
         prior_in[s]       = prior_ff[s];
         prior_valid_in[s] = prior_valid_ff[s];
         abs_in[s]         = abs_ff[s];
         zero_in[s]        = zero_ff[s];
         rep_in[s]         = rep_ff[s];
         if (cmd.clear) begin
            min_in[s]         = smbhm_pkg::SAMPLE_MAX_C;
            max_in[s]         = smbhm_pkg::SAMPLE_MIN_C;
            prior_in[s]       = '0;
            prior_valid_in[s] = 1'b0;
            abs_in[s]         = '0;
            zero_in[s]        = '0;
            rep_in[s]         = '0;
         end else if (cmd.accum && take) begin
            if (sample[s] < min_ff[s]) min_in[s] = sample[s];
            if (sample[s] > max_ff[s]) max_in[s] = sample[s];
            abs_in[s] = abs_ff[s] + SUM_W'(mag[s]);
            if (sample[s] == '0) zero_in[s] = zero_ff[s] + 1'b1;
            if (prior_valid_ff[s] && (sample[s] == prior_ff[s])) begin
               rep_in[s] = rep_ff[s] + 1'b1;
            end
            prior_in[s]       = sample[s];
            prior_valid_in[s] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= smbhm_pkg::THRESH_RESET;
         frames_ff <= '0;
         for (int s = 0; s < 2; s++) begin
            min_ff[s]         <= smbhm_pkg::SAMPLE_MAX_C;
            max_ff[s]         <= smbhm_pkg::SAMPLE_MIN_C;
            prior_ff[s]       <= '0;
            prior_valid_ff[s] <= 1'b0;
            abs_ff[s]         <= '0;
            zero_ff[s]        <= '0;
            rep_ff[s]         <= '0;
         end
      end else begin
         thresh_ff <= thresh_in;
         frames_ff <= frames_in;
         for (int s = 0; s < 2; s++) begin
            min_ff[s]         <= min_in[s];
            max_ff[s]         <= max_in[s];
            prior_ff[s]       <= prior_in[s];
            prior_valid_ff[s] <= prior_valid_in[s];
            abs_ff[s]         <= abs_in[s];
            zero_ff[s]        <= zero_in[s];
            rep_ff[s]         <= rep_in[s];
         end
      end
   end

   smbhm_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (abs_ff[cmd.slot]),
      .divisor  (frames_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign stat.div_busy = div_busy;

   // result fields for the selected slot
   assign empty    = (frames_ff == '0);
   assign sel_min  = min_ff[cmd.slot];
   assign sel_max  = max_ff[cmd.slot];
   assign range_c  = empty ? '0 : SW'(sel_max - sel_min);
   assign rep_plus = {1'b0, rep_ff[cmd.slot]} + 1'b1;

   always_comb begin
      priority if (empty) begin
         status_c = smbhm_pkg::ST_NO_DATA;
      end else if (zero_ff[cmd.slot] == frames_ff) begin
         status_c = smbhm_pkg::ST_ALL_ZERO;
      end else if (rep_plus >= {1'b0, frames_ff}) begin
         status_c = smbhm_pkg::ST_STUCK;
      end else if (range_c < thresh_ff) begin
         status_c = smbhm_pkg::ST_LOW_VAR;
      end else begin
         status_c = smbhm_pkg::ST_ACTIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_slot_ff        <= cmd.slot;
         rsp_status_ff      <= status_c;
         rsp_frame_count_ff <= smbhm_pkg::COUNT_OUT_W'(frames_ff);
         rsp_min_ff         <= empty ? '0 : sel_min;
         rsp_max_ff         <= empty ? '0 : sel_max;
         rsp_range_ff       <= range_c;
         rsp_mean_ff        <= empty ? '0 : quotient[SW-1:0];
         rsp_zero_ff        <= smbhm_pkg::COUNT_OUT_W'(zero_ff[cmd.slot]);
         rsp_repeat_ff      <= smbhm_pkg::REPEAT_OUT_W'(rep_ff[cmd.slot]);
      end
   end

   assign rsp_slot           = rsp_slot_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_frame_count    = rsp_frame_count_ff;
   assign rsp_min_sample     = rsp_min_ff;
   assign rsp_max_sample     = rsp_max_ff;
   assign rsp_sample_range   = rsp_range_ff;
   assign rsp_mean_abs       = rsp_mean_ff;
   assign rsp_zero_samples   = rsp_zero_ff;
   assign rsp_repeat_samples = rsp_repeat_ff;
   assign rsp_last_result    = rsp_slot_ff;

endmodule

// ----- rtl/smbhm_ctrl.sv -----
// Controller state machine: input handshake, per-slot report sequencing.
// Depends on smbhm_pkg.
module smbhm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_end_of_block,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output smbhm_pkg::cmd_type  cmd,
   input  smbhm_pkg::stat_type stat
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ACCUM = 5'b00010,
      S_START = 5'b00100,
      S_DIV   = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      slot_ff, slot_in;
   logic      eob_ff, eob_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      eob_in        = eob_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd           = '0;
      cmd.slot      = slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               eob_in      = req_end_of_block;
               state_in    = S_ACCUM;
            end
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            slot_in   = 1'b0;
            state_in  = eob_ff ? S_START : S_IDLE;
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (slot_ff) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  slot_in  = 1'b1;
                  state_in = S_START;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= 1'b0;
         eob_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         eob_ff       <= eob_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/stereo_mic_block_health_monitor.sv -----
// Stereo mic block health monitor top level (smbhm_pkg, smbhm_ctrl, smbhm_dp).
// A beat without end of block is captured, then updates the statistics; an
// end-of-block beat then runs, per slot, divider start, bit-serial division and
// result load, with the result held while rsp_stall is high. One beat in flight
// at a time; after end of block, req_stall is high until both results are taken.
// Synchronous reset clears statistics, threshold (to 64) and control; no sweep.
module stereo_mic_block_health_monitor #(
   parameter int BLOCK_FRAMES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [smbhm_pkg::RAW_W-1:0]     req_left_raw,
   input  logic signed [smbhm_pkg::RAW_W-1:0]     req_right_raw,
   input  logic                                   req_has_frame,
   input  logic                                   req_end_of_block,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_slot,
   output logic [smbhm_pkg::STATUS_W-1:0]         rsp_status,
   output logic [smbhm_pkg::COUNT_OUT_W-1:0]      rsp_frame_count,
   output logic signed [smbhm_pkg::SAMPLE_W-1:0]  rsp_min_sample,
   output logic signed [smbhm_pkg::SAMPLE_W-1:0]  rsp_max_sample,
   output logic [smbhm_pkg::SAMPLE_W-1:0]         rsp_sample_range,
   output logic [smbhm_pkg::SAMPLE_W-1:0]         rsp_mean_abs,
   output logic [smbhm_pkg::COUNT_OUT_W-1:0]      rsp_zero_samples,
   output logic [smbhm_pkg::REPEAT_OUT_W-1:0]     rsp_repeat_samples,
   output logic                                   rsp_last_result,
   // variation threshold register
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [smbhm_pkg::THRESH_W-1:0]         csr_data
);

   smbhm_pkg::cmd_type  cmd;
   smbhm_pkg::stat_type stat;
   logic                csr_write;

   // Threshold writes must land only while idle; the user is bound to this, and the block keeps csr_ready high.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Sequencer: capture, update, then at end of block per slot divide, load and
   // hold the result beat until taken; clear the statistics after the right slot.
   smbhm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_block (req_end_of_block),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .stat             (stat)
   );

   // Statistics for both slots, the mean divider and the result register.
   smbhm_dp #(
      .BLOCK_FRAMES (BLOCK_FRAMES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_left_raw       (req_left_raw),
      .req_right_raw      (req_right_raw),
      .req_has_frame      (req_has_frame),
      .csr_write          (csr_write),
      .csr_data           (csr_data),
      .rsp_slot           (rsp_slot),
      .rsp_status         (rsp_status),
      .rsp_frame_count    (rsp_frame_count),
      .rsp_min_sample     (rsp_min_sample),
      .rsp_max_sample     (rsp_max_sample),
      .rsp_sample_range   (rsp_sample_range),
      .rsp_mean_abs       (rsp_mean_abs),
      .rsp_zero_samples   (rsp_zero_samples),
      .rsp_repeat_samples (rsp_repeat_samples),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

// ----- rtl/smbhm_checker.sv -----
// Port-level checker for the stereo mic block health monitor, bound to the top.
// Depends on smbhm_pkg and stereo_mic_block_health_monitor_assert.svh.
`include "stereo_mic_block_health_monitor_assert.svh"

module smbhm_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic                                   rsp_slot,
   input logic [smbhm_pkg::STATUS_W-1:0]         rsp_status,
   input logic [smbhm_pkg::COUNT_OUT_W-1:0]      rsp_frame_count,
   input logic signed [smbhm_pkg::SAMPLE_W-1:0]  rsp_min_sample,
   input logic signed [smbhm_pkg::SAMPLE_W-1:0]  rsp_max_sample,
   input logic [smbhm_pkg::SAMPLE_W-1:0]         rsp_sample_range,
   input logic [smbhm_pkg::SAMPLE_W-1:0]         rsp_mean_abs,
   input logic                                   rsp_last_result
);

   `SMBHM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_slot) && $stable(rsp_status) && $stable(rsp_mean_abs), "result beat changed while stalled")

   `SMBHM_ASSERT_NOW(a_last_is_right, rsp_valid, rsp_last_result == rsp_slot, "last_result does not match slot")

   `SMBHM_ASSERT_NOW(a_empty_zero, rsp_valid && (rsp_status == smbhm_pkg::ST_NO_DATA), (rsp_frame_count == '0) && (rsp_min_sample == '0) && (rsp_max_sample == '0) && (rsp_sample_range == '0) && (rsp_mean_abs == '0), "empty block reports nonzero fields")

   `SMBHM_ASSERT_NOW(a_range, rsp_valid && (rsp_status != smbhm_pkg::ST_NO_DATA), (rsp_min_sample <= rsp_max_sample) && (rsp_sample_range == 24'(rsp_max_sample - rsp_min_sample)), "range inconsistent with min and max")

   `SMBHM_ASSERT_NOW(a_no_accept_while_reporting, rsp_valid, req_stall, "input accepted while a result is pending")

endmodule

bind stereo_mic_block_health_monitor smbhm_checker u_smbhm_checker (.*);
